// ----- sv/amfp_pkg.sv -----
// Shared types, constants and a helper function for the ASCII monitor frame parser.
`default_nettype none
package amfp_pkg;

  localparam int VAL_W = 32;
  localparam int SUM_W = 64;
  localparam int IDX_W = 5;
  localparam int CNT_W = 6;

  // Result status codes.
  localparam logic [1:0] ST_VALUE = 2'd0;
  localparam logic [1:0] ST_ADDR  = 2'd1;
  localparam logic [1:0] ST_CSUM  = 2'd2;
  localparam logic [1:0] ST_PARSE = 2'd3;

  // Characters of the line format.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_FIVE   = 8'h35;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_R      = 8'h72;

  // Prefix match progress.
  localparam logic [2:0] PFX_COLON = 3'd0;
  localparam logic [2:0] PFX_R     = 3'd1;
  localparam logic [2:0] PFX_FIVE  = 3'd2;
  localparam logic [2:0] PFX_KIND  = 3'd3;
  localparam logic [2:0] PFX_EQUAL = 3'd4;
  localparam logic [2:0] PFX_BODY  = 3'd5;

  // Token scan phase.
  localparam logic [1:0] TP_START  = 2'd0;
  localparam logic [1:0] TP_SIGNED = 2'd1;
  localparam logic [1:0] TP_DIGITS = 2'd2;

  localparam logic [IDX_W-1:0] STATUS_VALUES   = 5'd14;
  localparam logic [IDX_W-1:0] SETTINGS_VALUES = 5'd25;
  localparam logic [VAL_W-1:0] SAT_MAG         = 32'h8000_0000;
  localparam logic [VAL_W-1:0] SAT_POS         = 32'h7FFF_FFFF;
  localparam logic [CNT_W-1:0] COUNT_MAX       = 6'd63;
  localparam logic [7:0]       MOD_BASE        = 8'd255;

  // One line's outcome, handed from the front to the back.
  typedef struct packed {
    logic             kind;
    logic [1:0]       status;
    logic [IDX_W-1:0] count;
    logic             bank;
  } desc_t;

  // Control fields of one result.
  typedef struct packed {
    logic             kind;
    logic [1:0]       status;
    logic [IDX_W-1:0] idx;
    logic             last;
  } res_ctl_t;

  // Residue of a 32-bit two's complement value modulo 255, in 0..254.
  // Since 256 is 1 modulo 255, bytes are summed and 2^32 counts as 1.
  function automatic logic [7:0] residue255(input logic [VAL_W-1:0] u);
    logic [9:0] x;
    logic [8:0] y;
    logic [8:0] z;
    x = 10'(u[7:0]) + 10'(u[15:8]) + 10'(u[23:16]) + 10'(u[31:24]) - 10'(u[31]);
    y = 9'(x[9:8]) + 9'(x[7:0]);
    z = 9'(y[8]) + 9'(y[7:0]);
    return (z == 9'(MOD_BASE)) ? 8'd0 : z[7:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/amfp_ram.sv -----
// Generic single write port, single registered read port RAM.
`default_nettype none
module amfp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/amfp_desc_queue.sv -----
// Two-entry queue of line outcomes between the front and the back.
`default_nettype none
module amfp_desc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  amfp_pkg::desc_t    push_desc,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output amfp_pkg::desc_t    pop_desc
);

  amfp_pkg::desc_t slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign push_ready = (cnt != 2'd2);
  assign pop_valid  = (cnt != 2'd0);
  assign pop_desc   = slots[rp];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_desc;
    end
  end

endmodule
`default_nettype wire

// ----- sv/amfp_front.sv -----
// Front end: byte classification, prefix match, token parsing and line verdict.
`default_nettype none
module amfp_front #(
  parameter int LINE_LIMIT  = 128,
  parameter int VALUE_SLOTS = 25
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                rx_byte,
  input  wire logic                      cfg_valid,
  input  wire logic [7:0]                cfg_data,
  output logic                           desc_valid,
  input  wire logic                      desc_ready,
  output amfp_pkg::desc_t                desc,
  input  wire logic [1:0]                bank_release,
  output logic                           ram_we,
  output logic [amfp_pkg::IDX_W:0]       ram_waddr,
  output logic [amfp_pkg::VAL_W-1:0]     ram_wdata
);

  localparam int PW = $clog2(LINE_LIMIT);

  logic [7:0]                    dev_addr;
  logic [PW-1:0]                 pos;
  logic [2:0]                    prefix;
  logic                          ignored;
  logic                          ftype;
  logic [amfp_pkg::VAL_W-1:0]    acc;
  logic [1:0]                    phase;
  logic                          neg;
  logic [amfp_pkg::CNT_W-1:0]    count;
  logic                          stopped;
  logic [amfp_pkg::VAL_W-1:0]    frame_addr;
  logic [amfp_pkg::VAL_W-1:0]    frame_csum;
  logic [amfp_pkg::SUM_W-1:0]    sum;
  logic [7:0]                    res;
  logic                          tok_valid;
  logic [amfp_pkg::VAL_W-1:0]    tok_v;
  logic                          eol_valid;
  logic                          eol_ok;
  logic                          eol_kind;
  logic [amfp_pkg::CNT_W-1:0]    eol_count;
  logic                          wbank;
  logic [1:0]                    busy;

  logic                          accept;
  logic                          skip;
  logic                          is_lf;
  logic                          in_line;
  logic                          digit;
  logic                          blank;
  logic                          ender;
  logic [3:0]                    dval;
  logic [35:0]                   acc_mul;
  logic [amfp_pkg::VAL_W-1:0]    acc_sat;
  logic [amfp_pkg::VAL_W-1:0]    tok_bits;
  logic                          finish;
  logic [amfp_pkg::CNT_W-1:0]    slot;
  logic [1:0]                    status;
  logic [amfp_pkg::IDX_W-1:0]    need;
  logic [9:0]                    rem;
  logic [9:0]                    rem_p1;
  logic                          eol_push;
  logic                          eol_fire;
  logic [8:0]                    res_sum;

  // Byte classification.
  assign accept  = in_valid && in_ready;
  assign skip    = (rx_byte == amfp_pkg::CH_NUL) || rx_byte[7] || (rx_byte == amfp_pkg::CH_CR);
  assign is_lf   = (rx_byte == amfp_pkg::CH_LF);
  assign in_line = (pos < PW'(LINE_LIMIT - 1));
  assign digit   = (rx_byte >= amfp_pkg::CH_ZERO) && (rx_byte <= amfp_pkg::CH_NINE);
  assign blank   = (rx_byte == amfp_pkg::CH_SPACE) || (rx_byte == amfp_pkg::CH_TAB) ||
                   (rx_byte == amfp_pkg::CH_VT) || (rx_byte == amfp_pkg::CH_FF);
  assign ender   = (rx_byte == amfp_pkg::CH_COMMA) || (rx_byte == amfp_pkg::CH_PERIOD);
  assign dval    = 4'(rx_byte - amfp_pkg::CH_ZERO);

  // Decimal accumulate with saturation at 2^31.
  assign acc_mul = 36'(acc) * 36'd10 + 36'(dval);
  assign acc_sat = (acc_mul > 36'(amfp_pkg::SAT_MAG)) ? amfp_pkg::SAT_MAG : acc_mul[31:0];

  // Token value clamped to the signed 32-bit range.
  always_comb begin
    if (neg) begin
      tok_bits = acc[31] ? amfp_pkg::SAT_MAG : (~acc + 32'd1);
    end else begin
      tok_bits = acc[31] ? amfp_pkg::SAT_POS : acc;
    end
  end

  assign finish = accept && !skip && !is_lf && in_line && !ignored &&
                  (prefix == amfp_pkg::PFX_BODY) && !stopped &&
                  (phase == amfp_pkg::TP_DIGITS) && ender;

  // Value store write for tokens after the checksum.
  assign slot      = count - 6'd2;
  assign ram_we    = finish && (count >= 6'd2) && (slot < amfp_pkg::CNT_W'(VALUE_SLOTS));
  assign ram_waddr = {wbank, slot[amfp_pkg::IDX_W-1:0]};
  assign ram_wdata = tok_bits;

  // C remainder of the sum from its residue and sign.
  always_comb begin
    if (sum[amfp_pkg::SUM_W-1]) begin
      rem = (res == 8'd0) ? 10'd0 : (10'(res) - 10'(amfp_pkg::MOD_BASE));
    end else begin
      rem = 10'(res);
    end
  end
  assign rem_p1 = rem + 10'd1;

  // Line verdict in the order of the rejection rules.
  assign need = eol_kind ? amfp_pkg::SETTINGS_VALUES : amfp_pkg::STATUS_VALUES;
  always_comb begin
    if (eol_count < 6'd1) begin
      status = amfp_pkg::ST_PARSE;
    end else if (frame_addr != 32'(dev_addr)) begin
      status = amfp_pkg::ST_ADDR;
    end else if (eol_count < 6'd2) begin
      status = amfp_pkg::ST_PARSE;
    end else if (frame_csum != {{22{rem_p1[9]}}, rem_p1}) begin
      status = amfp_pkg::ST_CSUM;
    end else if (eol_count < 6'(need) + 6'd2) begin
      status = amfp_pkg::ST_PARSE;
    end else begin
      status = amfp_pkg::ST_VALUE;
    end
  end

  assign eol_push    = eol_valid && eol_ok;
  assign eol_fire    = eol_valid && (!eol_ok || desc_ready);
  assign desc_valid  = eol_push;
  assign desc.kind   = eol_kind;
  assign desc.status = status;
  assign desc.count  = need;
  assign desc.bank   = wbank;

  // Hold input while the verdict waits or the write bank is still being read.
  assign in_ready = !busy[wbank] && !(eol_valid && !eol_fire);

  assign res_sum = 9'(res) + 9'(amfp_pkg::residue255(tok_v));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= 8'd1;
    end else if (cfg_valid) begin
      dev_addr <= cfg_data;
    end
  end

  // Per-line parse state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      prefix     <= amfp_pkg::PFX_COLON;
      ignored    <= 1'b0;
      ftype      <= 1'b0;
      acc        <= '0;
      phase      <= amfp_pkg::TP_START;
      neg        <= 1'b0;
      count      <= '0;
      stopped    <= 1'b0;
      frame_addr <= '0;
      frame_csum <= '0;
      tok_valid  <= 1'b0;
      tok_v      <= '0;
      eol_valid  <= 1'b0;
      eol_ok     <= 1'b0;
      eol_kind   <= 1'b0;
      eol_count  <= '0;
    end else begin
      tok_valid <= finish;
      if (finish) begin
        tok_v <= tok_bits;
      end
      if (eol_fire) begin
        eol_valid <= 1'b0;
      end
      if (accept && !skip) begin
        if (is_lf) begin
          eol_valid <= 1'b1;
          eol_ok    <= !ignored && (prefix == amfp_pkg::PFX_BODY);
          eol_kind  <= ftype;
          eol_count <= count;
          pos       <= '0;
          prefix    <= amfp_pkg::PFX_COLON;
          ignored   <= 1'b0;
          ftype     <= 1'b0;
          acc       <= '0;
          phase     <= amfp_pkg::TP_START;
          neg       <= 1'b0;
          count     <= '0;
          stopped   <= 1'b0;
        end else if (in_line) begin
          pos <= pos + PW'(1);
          if (!ignored) begin
            if (prefix != amfp_pkg::PFX_BODY) begin
              // Prefix match.
              case (prefix)
                amfp_pkg::PFX_COLON: begin
                  if (rx_byte == amfp_pkg::CH_COLON) prefix <= amfp_pkg::PFX_R;
                  else ignored <= 1'b1;
                end
                amfp_pkg::PFX_R: begin
                  if (rx_byte == amfp_pkg::CH_R) prefix <= amfp_pkg::PFX_FIVE;
                  else ignored <= 1'b1;
                end
                amfp_pkg::PFX_FIVE: begin
                  if (rx_byte == amfp_pkg::CH_FIVE) prefix <= amfp_pkg::PFX_KIND;
                  else ignored <= 1'b1;
                end
                amfp_pkg::PFX_KIND: begin
                  ftype <= (rx_byte == amfp_pkg::CH_ONE);
                  if ((rx_byte == amfp_pkg::CH_ZERO) || (rx_byte == amfp_pkg::CH_ONE)) begin
                    prefix <= amfp_pkg::PFX_EQUAL;
                  end else begin
                    ignored <= 1'b1;
                  end
                end
                default: begin
                  if (rx_byte == amfp_pkg::CH_EQUAL) prefix <= amfp_pkg::PFX_BODY;
                  else ignored <= 1'b1;
                end
              endcase
            end else if (!stopped) begin
              // Token scan.
              case (phase)
                amfp_pkg::TP_START: begin
                  if ((rx_byte == amfp_pkg::CH_PLUS) || (rx_byte == amfp_pkg::CH_MINUS)) begin
                    neg   <= (rx_byte == amfp_pkg::CH_MINUS);
                    phase <= amfp_pkg::TP_SIGNED;
                  end else if (digit) begin
                    acc   <= 32'(dval);
                    phase <= amfp_pkg::TP_DIGITS;
                  end else if (!blank) begin
                    stopped <= 1'b1;
                  end
                end
                amfp_pkg::TP_SIGNED: begin
                  if (digit) begin
                    acc   <= 32'(dval);
                    phase <= amfp_pkg::TP_DIGITS;
                  end else begin
                    stopped <= 1'b1;
                  end
                end
                default: begin
                  if (digit) begin
                    acc <= acc_sat;
                  end else if (ender) begin
                    if (count == 6'd0) frame_addr <= tok_bits;
                    if (count == 6'd1) frame_csum <= tok_bits;
                    if (count < amfp_pkg::COUNT_MAX) count <= count + 6'd1;
                    acc   <= '0;
                    phase <= amfp_pkg::TP_START;
                    neg   <= 1'b0;
                  end else begin
                    stopped <= 1'b1;
                  end
                end
              endcase
            end
          end
        end
      end
    end
  end

  // Running sum and its residue, updated from the registered token value.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      res <= '0;
    end else if (eol_fire) begin
      sum <= '0;
      res <= '0;
    end else if (tok_valid && (count >= 6'd3)) begin
      sum <= sum + {{(amfp_pkg::SUM_W - amfp_pkg::VAL_W){tok_v[31]}}, tok_v};
      res <= (res_sum >= 9'(amfp_pkg::MOD_BASE)) ? 8'(res_sum - 9'(amfp_pkg::MOD_BASE))
                                                 : res_sum[7:0];
    end
  end

  // Store banks: filled by the front, released by the back.
  always_ff @(posedge clk) begin
    if (rst) begin
      wbank <= 1'b0;
      busy  <= 2'b00;
    end else begin
      if (eol_push && desc_ready && (status == amfp_pkg::ST_VALUE)) begin
        busy  <= (busy | (2'b01 << wbank)) & ~bank_release;
        wbank <= ~wbank;
      end else begin
        busy <= busy & ~bank_release;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/amfp_back.sv -----
// Back end: expands line outcomes into results and buffers them for the output.
`default_nettype none
module amfp_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      desc_valid,
  output logic                           desc_ready,
  input  amfp_pkg::desc_t                desc,
  output logic [1:0]                     bank_release,
  output logic [amfp_pkg::IDX_W:0]       ram_raddr,
  input  wire logic [amfp_pkg::VAL_W-1:0] ram_rdata,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           frame_kind,
  output logic [1:0]                     result_status,
  output logic [amfp_pkg::IDX_W-1:0]     value_index,
  output logic signed [amfp_pkg::VAL_W-1:0] value_out,
  output logic                           last_of_run
);

  amfp_pkg::desc_t             cur;
  logic                        active;
  logic [amfp_pkg::IDX_W-1:0]  k;
  logic                        s1_valid;
  amfp_pkg::res_ctl_t          s1_ctl;
  amfp_pkg::res_ctl_t          fifo_ctl [4];
  logic [amfp_pkg::VAL_W-1:0]  fifo_val [4];
  logic [1:0]                  wp;
  logic [1:0]                  rp;
  logic [2:0]                  cnt;

  logic                        issue;
  logic                        is_value;
  logic                        last;
  logic                        pop;
  amfp_pkg::res_ctl_t          head;

  // Issue a result only when the buffer has room for it.
  assign issue      = active && ((cnt + 3'(s1_valid)) <= 3'd2);
  assign is_value   = (cur.status == amfp_pkg::ST_VALUE);
  assign last       = !is_value || (k == cur.count - 5'd1);
  assign desc_ready = !active;
  assign ram_raddr  = {cur.bank, k};
  assign bank_release = (issue && last && is_value) ? (2'b01 << cur.bank) : 2'b00;

  // Run sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      k        <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      if (!active) begin
        if (desc_valid) begin
          active <= 1'b1;
          k      <= '0;
        end
      end else if (issue) begin
        if (last) active <= 1'b0;
        else      k      <= k + 5'd1;
      end
    end
  end

  // Descriptor and result control payload.
  always_ff @(posedge clk) begin
    if (!active && desc_valid) begin
      cur <= desc;
    end
    if (issue) begin
      s1_ctl.kind   <= cur.kind;
      s1_ctl.status <= cur.status;
      s1_ctl.idx    <= is_value ? k : '0;
      s1_ctl.last   <= last;
    end
  end

  // Output buffer transfer bookkeeping.
  assign pop = out_valid && out_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (s1_valid) wp <= wp + 2'd1;
      if (pop)      rp <= rp + 2'd1;
      cnt <= cnt + 3'(s1_valid) - 3'(pop);
    end
  end

  // Output buffer storage; rejections carry a zero value.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      fifo_ctl[wp] <= s1_ctl;
      fifo_val[wp] <= (s1_ctl.status == amfp_pkg::ST_VALUE) ? ram_rdata : '0;
    end
  end

  assign head          = fifo_ctl[rp];
  assign out_valid     = (cnt != 3'd0);
  assign frame_kind    = head.kind;
  assign result_status = head.status;
  assign value_index   = head.idx;
  assign last_of_run   = head.last;
  assign value_out     = fifo_val[rp];

endmodule
`default_nettype wire

// ----- sv/ascii_monitor_frame_parser.sv -----
// Top level of the ASCII monitor frame parser: front, line queue, store and back.
// Throughput: one byte per cycle while the write bank is free and no verdict waits; one
// result per cycle while the output is ready. A line feed's first result passes through
// verdict, queue, descriptor, store read, output buffer; a run streams from the store.
// Two store banks let a new line fill while the previous run drains.
// Reset: synchronous, active high; device address returns to 1, all queues empty.
`default_nettype none
module ascii_monitor_frame_parser #(
  parameter int LINE_LIMIT  = 128,
  parameter int VALUE_SLOTS = 25
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                rx_byte,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [7:0]                device_address,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           frame_kind,
  output logic [1:0]                     result_status,
  output logic [4:0]                     value_index,
  output logic signed [31:0]             value_out,
  output logic                           last_of_run
);

  logic                          f_desc_valid;
  logic                          f_desc_ready;
  amfp_pkg::desc_t               f_desc;
  logic                          b_desc_valid;
  logic                          b_desc_ready;
  amfp_pkg::desc_t               b_desc;
  logic [1:0]                    bank_release;
  logic                          ram_we;
  logic [amfp_pkg::IDX_W:0]      ram_waddr;
  logic [amfp_pkg::VAL_W-1:0]    ram_wdata;
  logic [amfp_pkg::IDX_W:0]      ram_raddr;
  logic [amfp_pkg::VAL_W-1:0]    ram_rdata;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  amfp_front #(
    .LINE_LIMIT  (LINE_LIMIT),
    .VALUE_SLOTS (VALUE_SLOTS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .cfg_valid    (cfg_valid),
    .cfg_data     (device_address),
    .desc_valid   (f_desc_valid),
    .desc_ready   (f_desc_ready),
    .desc         (f_desc),
    .bank_release (bank_release),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata)
  );

  amfp_desc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_desc_valid),
    .push_ready (f_desc_ready),
    .push_desc  (f_desc),
    .pop_valid  (b_desc_valid),
    .pop_ready  (b_desc_ready),
    .pop_desc   (b_desc)
  );

  amfp_ram #(
    .WIDTH (amfp_pkg::VAL_W),
    .DEPTH (2 ** (amfp_pkg::IDX_W + 1))
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  amfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .desc_valid    (b_desc_valid),
    .desc_ready    (b_desc_ready),
    .desc          (b_desc),
    .bank_release  (bank_release),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_kind    (frame_kind),
    .result_status (result_status),
    .value_index   (value_index),
    .value_out     (value_out),
    .last_of_run   (last_of_run)
  );

endmodule
`default_nettype wire
